### sv/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`default_nettype none

package bpc_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned EV_W        = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_BUTTONS = 3;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 8;

  // Configuration register indexes; hold times sit at the button number.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd3;

  localparam logic [TIME_W-1:0] HOLD_ONE_RST   = 32'd1000;
  localparam logic [TIME_W-1:0] HOLD_TWO_RST   = 32'd1000;
  localparam logic [TIME_W-1:0] HOLD_THREE_RST = 32'd10000;
  localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 32'd10;

  localparam logic [MAX_BUTTONS-1:0][TIME_W-1:0] HOLD_RST =
    {HOLD_THREE_RST, HOLD_TWO_RST, HOLD_ONE_RST};

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [EV_W-1:0] EV_NONE = 3'd0;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_ev_t;

endpackage

`default_nettype wire

### sv/button_press_classifier.sv
// Top level of the three-button short/long press classifier.
`default_nettype none

// One request is taken per clock cycle whenever the result register is empty
// or its result is being taken in the same cycle; each result is registered
// and appears in the cycle after its request. That rate is set by the per-button
// lanes, each doing its two wrapping time compares and state update in the same
// cycle as the request, and by the single latched event slot that the merge
// stage updates in the same cycle. Configuration writes take effect on the next cycle.
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // now_ms[31:0], pin_levels[34:32]
  input  wire logic                  s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // event_res[2:0]
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [TIME_W-1:0]     cfg_data_i
);

  logic [BUTTON_COUNT-1:0][TIME_W-1:0] hold_q;
  logic [TIME_W-1:0]                   debounce_q;

  logic                    in_acc;
  logic                    sample;
  logic [TIME_W-1:0]       now_ms;
  logic [MAX_BUTTONS-1:0]  pin_levels;
  logic [EV_W-1:0]         event_res;
  lane_ev_t [BUTTON_COUNT-1:0] lane_ev;

  assign now_ms     = s_axis_tdata[TIME_W-1:0];
  assign pin_levels = s_axis_tdata[TIME_W +: MAX_BUTTONS];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign sample     = in_acc && (s_axis_tuser == ACT_SAMPLE);

  // hold time of button b lives at register index b
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_hold
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hold_q[b] <= HOLD_RST[b];
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(b))) begin
        hold_q[b] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
    end else if (cfg_we_i && (cfg_idx_i == CFG_DEBOUNCE)) begin
      debounce_q <= cfg_data_i;
    end
  end

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    bpc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sample_i   (sample),
      .now_i      (now_ms),
      .level_i    (pin_levels[b]),
      .hold_i     (hold_q[b]),
      .debounce_i (debounce_q),
      .ev_o       (lane_ev[b])
    );
  end

  bpc_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .action_i    (s_axis_tuser),
    .ev_i        (lane_ev),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .event_o     (event_res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - EV_W){1'b0}}, event_res};

endmodule

`default_nettype wire

### sv/bpc_lane.sv
// One button: debounce window, press timing and short/long detection.
`default_nettype none

module bpc_lane
  import bpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              sample_i,
  input  wire logic [TIME_W-1:0] now_i,
  input  wire logic              level_i,
  input  wire logic [TIME_W-1:0] hold_i,
  input  wire logic [TIME_W-1:0] debounce_i,
  output lane_ev_t               ev_o
);

  logic              pin_q, pin_d;
  logic              long_q, long_d;
  logic [TIME_W-1:0] press_q, press_d;
  logic [TIME_W-1:0] change_q, change_d;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic              live;
  logic              fire_long;
  logic              fire_short;
  logic              pressed;
  logic              changed;

  assign since_change = now_i - change_q;
  assign since_press  = now_i - press_q;
  assign live         = sample_i && (since_change >= debounce_i);

  assign fire_long  = live && !level_i && !pin_q && (since_press >= hold_i) && !long_q;
  assign fire_short = live && level_i && !pin_q && !long_q;
  assign pressed    = live && !level_i && pin_q;
  assign changed    = live && (level_i != pin_q);

  always_comb begin
    pin_d    = pin_q;
    long_d   = long_q;
    press_d  = press_q;
    change_d = change_q;
    if (live) begin
      pin_d = level_i;
    end
    if (fire_long) begin
      long_d = 1'b1;
    end
    if (changed && level_i) begin
      long_d = 1'b0;
    end
    if (pressed) begin
      press_d = now_i;
    end
    if (changed) begin
      change_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q    <= 1'b1;
      long_q   <= 1'b0;
      press_q  <= '0;
      change_q <= '0;
    end else begin
      pin_q    <= pin_d;
      long_q   <= long_d;
      press_q  <= press_d;
      change_q <= change_d;
    end
  end

  assign ev_o.short_ev = fire_short;
  assign ev_o.long_ev  = fire_long;

`ifndef NO_ASSERTIONS
  // a long report only ever starts while the button is held
  a_long_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(long_q) |-> !pin_q)
    else $error("long flag set on a released button");
`endif

endmodule

`default_nettype wire

### sv/bpc_merge.sv
// Merges lane events into the latched slot and holds the result register.
`default_nettype none

module bpc_merge
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 acc_i,
  input  wire logic                 action_i,
  input  wire lane_ev_t [BUTTON_COUNT-1:0] ev_i,
  input  wire logic                 out_ready_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic [EV_W-1:0]           event_o
);

  logic [EV_W-1:0] latched_q, latched_d;
  logic [EV_W-1:0] res_q, res_d;
  logic            valid_q, valid_d;
  logic [EV_W-1:0] merged;

  // highest numbered lane wins
  always_comb begin
    merged = latched_q;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (ev_i[i].long_ev) begin
        merged = EV_W'(2 * i + 2);
      end else if (ev_i[i].short_ev) begin
        merged = EV_W'(2 * i + 1);
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    latched_d = latched_q;
    res_d     = res_q;
    valid_d   = valid_q && !out_ready_i;
    if (acc_i) begin
      valid_d = 1'b1;
      if (action_i == ACT_READ) begin
        res_d     = latched_q;
        latched_d = EV_NONE;
      end else begin
        res_d     = merged;
        latched_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= EV_NONE;
      valid_q   <= 1'b0;
    end else begin
      latched_q <= latched_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign event_o     = res_q;

`ifndef NO_ASSERTIONS
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |=> valid_q)
    else $error("accepted request produced no result");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (action_i == ACT_READ) |=> (latched_q == EV_NONE))
    else $error("read did not clear the event slot");

  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(latched_q))
    else $error("event slot changed without a request");
`endif

endmodule

`default_nettype wire

### bench/press_event_checker.sv
// Watches the classifier's streams, predicts each latched event and compares the results.
module press_event_checker
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,   // now_ms[31:0], pin_levels[34:32]
  input  logic                  s_user_i,   // action
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,   // event_res[2:0]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TIME_W-1:0]     cfg_data_i,
  output int                    failures_o,
  output int                    outstanding_o
);

  // event code of button b is 2b+1 for a short press, 2b+2 for a long one
  localparam int SHORT_CODE_OFS = 1;
  localparam int LONG_CODE_OFS  = 2;

  logic [TIME_W-1:0]      hold_cfg [MAX_BUTTONS];
  logic [TIME_W-1:0]      debounce_cfg;
  logic [MAX_BUTTONS-1:0] level_seen;
  logic [MAX_BUTTONS-1:0] long_sent;
  logic [TIME_W-1:0]      press_at [MAX_BUTTONS];
  logic [TIME_W-1:0]      change_at [MAX_BUTTONS];
  logic [EV_W-1:0]        slot_event;
  logic [EV_W-1:0]        event_q [$];
  int                     fail_tally;

  initial begin
    failures_o    = 0;
    outstanding_o = 0;
  end

  function automatic void classify_sample(input logic [TIME_W-1:0] now,
                                          input logic [MAX_BUTTONS-1:0] pins);
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      since_change = now - change_at[b];
      if (since_change >= debounce_cfg) begin
        since_press = now - press_at[b];
        if (!pins[b] && !level_seen[b] && since_press >= hold_cfg[b] && !long_sent[b]) begin
          slot_event   = EV_W'(2 * b + LONG_CODE_OFS);
          long_sent[b] = 1'b1;
        end
        if (pins[b] != level_seen[b]) begin
          if (pins[b]) begin
            if (!long_sent[b]) slot_event = EV_W'(2 * b + SHORT_CODE_OFS);
            long_sent[b] = 1'b0;
          end else begin
            press_at[b] = now;
          end
          change_at[b] = now;
        end
        level_seen[b] = pins[b];
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [EV_W-1:0] want;
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        hold_cfg[b]  = HOLD_RST[b];
        press_at[b]  = '0;
        change_at[b] = '0;
      end
      debounce_cfg = DEBOUNCE_RST;
      level_seen   = '1;
      long_sent    = '0;
      slot_event   = EV_NONE;
      event_q.delete();
      fail_tally   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HOLD_ONE:   hold_cfg[0]  = cfg_data_i;
          CFG_HOLD_TWO:   hold_cfg[1]  = cfg_data_i;
          CFG_HOLD_THREE: hold_cfg[2]  = cfg_data_i;
          CFG_DEBOUNCE:   debounce_cfg = cfg_data_i;
          default: ;
        endcase
      end
      // a result is always for an older request, so retire before queuing
      if (m_valid_i && m_ready_i) begin
        if (event_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, m_data_i);
          fail_tally++;
        end else begin
          want = event_q.pop_front();
          if (m_data_i !== OUT_DATA_W'(want)) begin
            $display("%0t: event_res mismatch, expected %0d, actual %0d",
                     $time, want, m_data_i);
            fail_tally++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == ACT_READ) begin
          event_q.push_back(slot_event);
          slot_event = EV_NONE;
        end else begin
          classify_sample(s_data_i[TIME_W-1:0], s_data_i[TIME_W +: MAX_BUTTONS]);
          event_q.push_back(slot_event);
        end
      end
    end
    failures_o    <= fail_tally;
    outstanding_o <= event_q.size();
  end

endmodule

### bench/button_press_classifier_tb.sv
// Stimulus and verdict for the button press classifier; checking is in press_event_checker.
module button_press_classifier_tb;
  import bpc_pkg::*;

  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_TOGGLE} ready_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = ACT_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_HOLD_ONE;
  logic [TIME_W-1:0]     cfg_data_i    = '0;

  int failures;
  int outstanding;

  // stimulus-side view of the settings and the pins, used only to shape the stimulus
  logic [TIME_W-1:0]      hold_ms [MAX_BUTTONS] = '{HOLD_ONE_RST, HOLD_TWO_RST, HOLD_THREE_RST};
  logic [TIME_W-1:0]      debounce_ms = DEBOUNCE_RST;
  logic [TIME_W-1:0]      clock_ms    = '0;
  logic [MAX_BUTTONS-1:0] pin_state   = '1;
  int unsigned            burst_left  = 0;

  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned ready_left = 0;

  always #5 clk_i = ~clk_i;

  button_press_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  press_event_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // result side: the stall pattern switches to a randomly chosen mode whenever its run counter runs out
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(16, 96);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:    m_axis_tready <= ~m_axis_tready;
    endcase
  end

  function automatic logic [TIME_W-1:0] clamp_span(input logic [TIME_W-1:0] x);
    return (x > 20000) ? 32'd20000 : x;
  endfunction

  // time advance between samples: inside and around debounce, around hold, or far
  function automatic logic [TIME_W-1:0] next_step();
    logic [TIME_W-1:0] slowest;
    slowest = hold_ms[0];
    for (int b = 1; b < MAX_BUTTONS; b++)
      if (hold_ms[b] > slowest) slowest = hold_ms[b];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, clamp_span(debounce_ms) * 2 + 1);
      4, 5, 6, 7: return $urandom_range(0, clamp_span(slowest) * 3 / 2 + 1);
      8:          return debounce_ms - $urandom_range(0, 1);
      default:    return $urandom();
    endcase
  endfunction

  task automatic push_request(input logic act, input logic [TIME_W-1:0] stamp,
                              input logic [MAX_BUTTONS-1:0] pins);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, pins, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [TIME_W-1:0] h0, input logic [TIME_W-1:0] h1,
                               input logic [TIME_W-1:0] h2, input logic [TIME_W-1:0] deb);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_HOLD_ONE;
    cfg_data_i <= h0;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOLD_TWO;
    cfg_data_i <= h1;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOLD_THREE;
    cfg_data_i <= h2;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DEBOUNCE;
    cfg_data_i <= deb;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    hold_ms     = '{h0, h1, h2};
    debounce_ms = deb;
  endtask

  task automatic run_directed();
    // samples inside the debounce window right after reset are dropped
    push_request(ACT_SAMPLE, 32'd0, 3'b110);
    push_request(ACT_SAMPLE, 32'd5, 3'b000);
    push_request(ACT_SAMPLE, 32'd10, 3'b110);
    push_request(ACT_READ, 32'hFFFF_FFFF, 3'b111);
    push_request(ACT_SAMPLE, 32'd15, 3'b111);
    push_request(ACT_SAMPLE, 32'd100, 3'b111);
    push_request(ACT_READ, 32'd0, 3'b000);
    push_request(ACT_READ, 32'd0, 3'b000);
    // all held: buttons one and two go long together, higher one wins
    push_request(ACT_SAMPLE, 32'd200, 3'b000);
    push_request(ACT_SAMPLE, 32'd1200, 3'b000);
    push_request(ACT_SAMPLE, 32'd10200, 3'b000);
    push_request(ACT_SAMPLE, 32'd10300, 3'b111);
    push_request(ACT_READ, 32'd0, 3'b000);
    // press across the timestamp wrap
    push_request(ACT_SAMPLE, 32'hFFFF_FFF0, 3'b101);
    push_request(ACT_SAMPLE, 32'd992, 3'b101);
    push_request(ACT_SAMPLE, 32'd2000, 3'b011);
    push_request(ACT_READ, 32'd0, 3'b000);
    push_request(ACT_SAMPLE, 32'd3000, 3'b111);
    push_request(ACT_READ, 32'd0, 3'b000);
    // release one short of and exactly at the debounce time
    push_request(ACT_SAMPLE, 32'd3010, 3'b110);
    push_request(ACT_SAMPLE, 32'd3019, 3'b111);
    push_request(ACT_SAMPLE, 32'd3020, 3'b111);
    push_request(ACT_READ, 32'd0, 3'b000);
    clock_ms  = 32'd3020;
    pin_state = 3'b111;
  endtask

  task automatic run_random(input int count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        push_request(ACT_READ, $urandom(), 3'($urandom()));
      end else if (pick < 25) begin
        pin_state = 3'($urandom());
        clock_ms += ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 64);
        push_request(ACT_SAMPLE, clock_ms, pin_state);
      end else begin
        // mostly one button pressed or released at a time, else held
        if ($urandom_range(0, 4) < 3) pin_state[$urandom_range(0, 2)] ^= 1'b1;
        clock_ms += next_step();
        push_request(ACT_SAMPLE, clock_ms, pin_state);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random(180);
    load_settings(32'd50, 32'd120, 32'd300, 32'd5);
    run_random(180);
    load_settings(32'd0, 32'd0, 32'd0, 32'd0);
    run_random(150);
    clock_ms = 32'hFFFF_F000;
    load_settings(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0);
    run_random(100);
    load_settings(32'd7, 32'hFFFF_FFFF, 32'd2000, 32'hFFFF_FFFF);
    run_random(40);
    load_settings($urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(0, 3000), $urandom_range(0, 50));
    run_random(120);
    load_settings($urandom_range(0, 400), $urandom_range(0, 400),
                  $urandom_range(0, 400), $urandom_range(0, 20));
    run_random(120);
    drain();
    repeat (4) @(posedge clk_i);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
